[src/esmf_pkg.sv]
// Shared types and constants for the encoder speed median filter.
// No dependencies; imported by esmf_median and encoder_speed_median_filter.
package esmf_pkg;

  // Field widths
  localparam int POSITION_W = 23;
  localparam int SPEED_W    = 19;
  localparam int DIFF_W     = 24;
  localparam int RAW_W      = 25;
  localparam int PRODUCT_W  = 35;
  localparam int PERIOD_W   = 16;
  localparam int STARTUP_W  = 6;
  localparam int SHIFT_W    = 5;

  // Stream payload widths (packed, padded to whole bytes)
  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 40;

  // Configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] REG_ENCODER_RESOLUTION = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SCALE_MODE         = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DECIMATION_PERIOD  = 2'd2;

  // Start-up length in samples
  localparam logic [STARTUP_W-1:0] STARTUP_SAMPLES = 6'd50;

  // Turn and half-turn for each resolution
  localparam logic signed [RAW_W-1:0] TURN_17 = 25'sd131072;
  localparam logic signed [RAW_W-1:0] HALF_17 = 25'sd65536;
  localparam logic signed [RAW_W-1:0] TURN_23 = 25'sd8388608;
  localparam logic signed [RAW_W-1:0] HALF_23 = 25'sd4194304;

  // Speed scale factor and right shifts
  localparam logic signed [11:0] SPEED_SCALE = 12'sd1875;
  localparam logic [SHIFT_W-1:0] SHIFT_17_MAGNETIC = 5'd9;
  localparam logic [SHIFT_W-1:0] SHIFT_17_OPTICAL  = 5'd12;
  localparam logic [SHIFT_W-1:0] SHIFT_23_MAGNETIC = 5'd15;
  localparam logic [SHIFT_W-1:0] SHIFT_23_OPTICAL  = 5'd18;

  typedef logic signed [SPEED_W-1:0] speed_t;

  // Status from the median unit back to the top level
  typedef struct packed {
    logic   done;
    speed_t median;
  } median_status_t;

endpackage

[src/encoder_speed_median_filter.sv]
// Encoder speed estimator with a decimated median filter; depends on esmf_pkg, esmf_median.
// A start-up sample goes straight to the output register; a normal sample passes through the
// difference, multiply and shift states, and one that enters a full window also waits in the
// sort state while the single comparator ranks every entry. One item is in flight, so the next
// input transaction is taken only once the last result is loaded into the output register.
// Reset clears control state; the window memory is fully written before its first read.
module encoder_speed_median_filter #(
  parameter int WINDOW_DEPTH = 16,
  parameter int MEDIAN_INDEX = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write port
  input  logic                              cfg_we,
  input  logic [esmf_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [esmf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // Input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [esmf_pkg::S_TDATA_W-1:0]    s_tdata,  // [22:0] position, [23] zero
  // Output stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [esmf_pkg::M_TDATA_W-1:0]    m_tdata,  // [18:0] actual_speed,
                                                      // [37:19] filtered_speed, [39:38] zero
  output logic                              m_tuser   // [0] filtered_valid
);
  import esmf_pkg::*;

  localparam int FW = $clog2(WINDOW_DEPTH + 3);
  localparam logic [FW-1:0] FILL_FULL  = FW'(WINDOW_DEPTH);
  localparam logic [FW-1:0] FILL_VALID = FW'(WINDOW_DEPTH + 2);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIFF  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_SHIFT = 3'd3;
  localparam logic [2:0] ST_SORT  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic                         encoder_resolution;
  logic                         scale_mode;
  logic [PERIOD_W-1:0]          decimation_period;

  logic [2:0]                   state;
  logic [POSITION_W-1:0]        pos_r;
  logic [POSITION_W-1:0]        prev_r;
  logic [POSITION_W-1:0]        previous_position;
  logic [STARTUP_W-1:0]         startup_count;
  logic [PERIOD_W-1:0]          decimation_count;
  logic [FW-1:0]                fill_count;
  speed_t                       speed_register;
  speed_t                       median_register;
  logic signed [DIFF_W-1:0]     diff_r;
  logic signed [PRODUCT_W-1:0]  product_r;

  logic [POSITION_W-1:0]        pos_m;
  logic [POSITION_W-1:0]        prev_m;
  logic signed [RAW_W-1:0]      raw_diff;
  logic signed [RAW_W-1:0]      wrapped;
  logic signed [RAW_W-1:0]      half;
  logic signed [RAW_W-1:0]      turn;
  logic signed [DIFF_W-1:0]     diff_next;
  logic [SHIFT_W-1:0]           shift_amt;
  logic signed [PRODUCT_W-1:0]  shifted;
  speed_t                       speed_next;

  logic                         win_wr;
  logic                         sort_start;
  median_status_t               med_status;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      encoder_resolution <= 1'b0;
      scale_mode         <= 1'b0;
      decimation_period  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ENCODER_RESOLUTION: encoder_resolution <= cfg_wdata[0];
        REG_SCALE_MODE:         scale_mode         <= cfg_wdata[0];
        REG_DECIMATION_PERIOD:  decimation_period  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Wrapped position difference
  always_comb begin
    pos_m    = encoder_resolution ? pos_r  : {6'b0, pos_r[16:0]};
    prev_m   = encoder_resolution ? prev_r : {6'b0, prev_r[16:0]};
    half     = encoder_resolution ? HALF_23 : HALF_17;
    turn     = encoder_resolution ? TURN_23 : TURN_17;
    raw_diff = $signed({2'b0, pos_m}) - $signed({2'b0, prev_m});
    if (raw_diff < -half) begin
      wrapped = raw_diff + turn;
    end else if (raw_diff > half) begin
      wrapped = raw_diff - turn;
    end else begin
      wrapped = raw_diff;
    end
    diff_next = wrapped[DIFF_W-1:0];
  end

  // Scale shift by resolution and encoder kind
  always_comb begin
    case ({encoder_resolution, scale_mode})
      2'b00:   shift_amt = SHIFT_17_OPTICAL;
      2'b01:   shift_amt = SHIFT_17_MAGNETIC;
      2'b10:   shift_amt = SHIFT_23_OPTICAL;
      default: shift_amt = SHIFT_23_MAGNETIC;
    endcase
    shifted    = product_r >>> shift_amt;
    speed_next = shifted[SPEED_W-1:0];
  end

  // Window entry and median start decisions in the shift cycle
  assign win_wr     = (state == ST_SHIFT) && (decimation_count >= decimation_period);
  assign sort_start = win_wr && (fill_count > FILL_FULL);

  esmf_median #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .MEDIAN_INDEX (MEDIAN_INDEX)
  ) u_median (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (win_wr),
    .wr_data (speed_next),
    .start   (sort_start),
    .status  (med_status)
  );

  assign s_tready = (state == ST_IDLE);

  // Sample sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      previous_position <= '0;
      startup_count     <= '0;
      decimation_count  <= '0;
      fill_count        <= '0;
      speed_register    <= '0;
      median_register   <= '0;
      m_tvalid          <= 1'b0;
    end else begin
      // Drop the result once taken, unless a new one loads in the same cycle
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            pos_r             <= s_tdata[POSITION_W-1:0];
            prev_r            <= previous_position;
            previous_position <= s_tdata[POSITION_W-1:0];
            if (startup_count < STARTUP_SAMPLES) begin
              startup_count <= startup_count + STARTUP_W'(1);
              state         <= ST_DONE;
            end else begin
              state <= ST_DIFF;
            end
          end
        end
        ST_DIFF: begin
          diff_r <= diff_next;
          state  <= ST_MUL;
        end
        ST_MUL: begin
          product_r <= PRODUCT_W'(diff_r) * PRODUCT_W'(SPEED_SCALE);
          state     <= ST_SHIFT;
        end
        ST_SHIFT: begin
          speed_register <= speed_next;
          if (decimation_count < decimation_period) begin
            decimation_count <= decimation_count + PERIOD_W'(1);
            state            <= ST_DONE;
          end else begin
            decimation_count <= '0;
            if (fill_count <= FILL_FULL) begin
              fill_count <= fill_count + FW'(1);
              state      <= ST_DONE;
            end else begin
              fill_count <= FILL_VALID;
              state      <= ST_SORT;
            end
          end
        end
        ST_SORT: begin
          if (med_status.done) begin
            median_register <= med_status.median;
            state           <= ST_DONE;
          end
        end
        ST_DONE: begin
          // Load the output register once it is free
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {2'b0, median_register, speed_register};
            m_tuser  <= (fill_count == FILL_VALID);
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Input is refused while a sample is in progress
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !s_tready)
    else $error("input ready while a sample is in progress");

  // Median unit completes only while the sequencer waits for it
  a_done_in_sort: assert property (@(posedge clk) disable iff (rst)
    med_status.done |-> (state == ST_SORT))
    else $error("median done outside the sort wait");

  // Filter valid status is sticky
  a_valid_sticky: assert property (@(posedge clk) disable iff (rst)
    (fill_count == FILL_VALID) |=> (fill_count == FILL_VALID))
    else $error("filtered valid status dropped");

  // Start-up counter never passes its limit
  a_startup_bound: assert property (@(posedge clk) disable iff (rst)
    startup_count <= STARTUP_SAMPLES)
    else $error("start-up counter overran");

endmodule

[src/esmf_median.sv]
// Median unit: circular window memory plus one shared comparator that ranks
// every entry against all others. Depends on esmf_pkg.
module esmf_median #(
  parameter int WINDOW_DEPTH = 16,
  parameter int MEDIAN_INDEX = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr_en,
  input  esmf_pkg::speed_t        wr_data,
  input  logic                    start,
  output esmf_pkg::median_status_t status
);
  import esmf_pkg::*;

  localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int MED_HI = (MEDIAN_INDEX < 1) ? 1 :
                          (MEDIAN_INDEX > WINDOW_DEPTH - 1) ? WINDOW_DEPTH - 1 : MEDIAN_INDEX;
  localparam logic [CW-1:0] RANK_HI = CW'(MED_HI);
  localparam logic [CW-1:0] RANK_LO = CW'(MED_HI - 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(WINDOW_DEPTH - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RANK = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  speed_t          mem [WINDOW_DEPTH];
  speed_t          rd_a;
  speed_t          rd_b;
  logic [AW-1:0]   wptr;
  logic [1:0]      state;
  logic [AW-1:0]   i_idx;
  logic [AW-1:0]   j_idx;
  logic [AW-1:0]   j_d;
  logic            cmp_v;
  logic [CW-1:0]   cnt;
  logic [CW-1:0]   cnt_next;
  logic            less;
  speed_t          lo;
  speed_t          hi;
  logic            done;
  logic [SPEED_W:0] mid_sum;

  // Window memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wptr] <= wr_data;
    end
    rd_a <= mem[i_idx];
    rd_b <= mem[j_idx];
  end

  // Shared comparator: stable ordering breaks ties by position
  always_comb begin
    less     = (rd_b < rd_a) || ((rd_b == rd_a) && (j_d < i_idx));
    cnt_next = cnt + CW'(less);
  end

  // Advance the write pointer round the window
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
    end else if (wr_en) begin
      wptr <= (wptr == LAST_IDX) ? '0 : wptr + AW'(1);
    end
  end

  // Ranking sequencer: outer loop over candidates, inner loop over entries
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      i_idx <= '0;
      j_idx <= '0;
      j_d   <= '0;
      cmp_v <= 1'b0;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            i_idx <= '0;
            j_idx <= '0;
            cnt   <= '0;
            cmp_v <= 1'b0;
            state <= S_RANK;
          end
        end
        S_RANK: begin
          cmp_v <= 1'b1;
          j_d   <= j_idx;
          if (cmp_v) begin
            cnt <= cnt_next;
          end
          if (j_idx == LAST_IDX) begin
            state <= S_FIN;
          end else begin
            j_idx <= j_idx + AW'(1);
          end
        end
        S_FIN: begin
          cmp_v <= 1'b0;
          cnt   <= '0;
          j_idx <= '0;
          if (i_idx == LAST_IDX) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            i_idx <= i_idx + AW'(1);
            state <= S_RANK;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Capture the two middle entries by rank
  always_ff @(posedge clk) begin
    if (state == S_FIN) begin
      if (cnt_next == RANK_LO) begin
        lo <= rd_a;
      end
      if (cnt_next == RANK_HI) begin
        hi <= rd_a;
      end
    end
  end

  // Mean of the middle pair, rounded toward minus infinity
  assign mid_sum       = {lo[SPEED_W-1], lo} + {hi[SPEED_W-1], hi};
  assign status.done   = done;
  assign status.median = mid_sum[SPEED_W:1];

endmodule

[sim/encoder_speed_median_filter_test.sv]
// Self-checking testbench for encoder_speed_median_filter: streams position samples,
// predicts speed and median results in a behavioral estimator, and checks each result.
// Depends on esmf_pkg and the encoder_speed_median_filter RTL.
module encoder_speed_median_filter_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW_DEPTH = 16;
  localparam int MEDIAN_INDEX = 8;

  // Estimator constants
  localparam int     STARTUP_LEN     = 50;
  localparam longint TURN_NARROW     = 131072;
  localparam longint HALF_NARROW     = 65536;
  localparam longint TURN_WIDE       = 8388608;
  localparam longint HALF_WIDE       = 4194304;
  localparam longint SPEED_SCALE_MUL = 1875;

  // Register index outside the defined register set
  localparam logic [esmf_pkg::CFG_ADDR_W-1:0] REG_UNMAPPED = 2'd3;

  typedef struct {
    logic signed [18:0] actual_speed;
    logic signed [18:0] filtered_speed;
    logic               filtered_valid;
  } speed_result_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              cfg_we = 1'b0;
  logic [esmf_pkg::CFG_ADDR_W-1:0]   cfg_addr = '0;
  logic [esmf_pkg::CFG_DATA_W-1:0]   cfg_wdata = '0;
  logic                              s_tvalid = 1'b0;
  logic                              s_tready;
  logic [esmf_pkg::S_TDATA_W-1:0]    s_tdata = '0;  // [22:0] position, [23] zero
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  logic [esmf_pkg::M_TDATA_W-1:0]    m_tdata;       // [18:0] actual_speed,
                                                    // [37:19] filtered_speed, [39:38] zero
  logic                              m_tuser;       // [0] filtered_valid

  encoder_speed_median_filter #(
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .MEDIAN_INDEX(MEDIAN_INDEX)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  always #1 clk = ~clk;

  // Stimulus and expected results
  logic [22:0]   pending_positions[$];
  speed_result_t expected_results[$];
  int            sender_idle_pct = 0;
  int            receiver_stall_pct = 0;
  int            mismatch_count = 0;
  logic [22:0]   walk_position = '0;

  // Estimator state mirror
  logic          resolution_23;
  logic          magnetic_scale;
  logic [15:0]   skip_period;
  logic [22:0]   last_position;
  int            startup_seen;
  int            skip_count;
  int            speed_history[WINDOW_DEPTH];
  int            entries;
  int            speed_now;
  int            median_now;

  function automatic void clear_estimator();
    resolution_23  = 1'b0;
    magnetic_scale = 1'b0;
    skip_period    = '0;
    last_position  = '0;
    startup_seen   = 0;
    skip_count     = 0;
    entries        = 0;
    speed_now      = 0;
    median_now     = 0;
    for (int i = 0; i < WINDOW_DEPTH; i++) speed_history[i] = 0;
  endfunction

  // Sort a copy of the window and average the two middle entries
  function automatic int window_median();
    int sorted_speeds[WINDOW_DEPTH];
    int v;
    int j;
    int m;
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      v = speed_history[i];
      j = i;
      while (j > 0 && sorted_speeds[j-1] > v) begin
        sorted_speeds[j] = sorted_speeds[j-1];
        j--;
      end
      sorted_speeds[j] = v;
    end
    m = MEDIAN_INDEX;
    if (m < 1) m = 1;
    if (m > WINDOW_DEPTH - 1) m = WINDOW_DEPTH - 1;
    return (sorted_speeds[m-1] + sorted_speeds[m]) >>> 1;
  endfunction

  // Advance the estimator by one sample and queue the result it produces
  function automatic void predict_speed_sample(logic [22:0] position);
    int            cur_pos;
    int            prev_pos;
    longint        delta;
    longint        turn;
    longint        half;
    int            shift;
    speed_result_t r;
    cur_pos = position;
    prev_pos = last_position;
    last_position = position;
    if (startup_seen < STARTUP_LEN) begin
      startup_seen++;
    end else begin
      if (!resolution_23) begin
        turn = TURN_NARROW;
        half = HALF_NARROW;
        cur_pos = cur_pos & 'h1FFFF;
        prev_pos = prev_pos & 'h1FFFF;
        shift = magnetic_scale ? 9 : 12;
      end else begin
        turn = TURN_WIDE;
        half = HALF_WIDE;
        shift = magnetic_scale ? 15 : 18;
      end
      delta = longint'(cur_pos) - longint'(prev_pos);
      if (delta < -half) delta = delta + turn;
      else if (delta > half) delta = delta - turn;
      speed_now = int'((delta * SPEED_SCALE_MUL) >>> shift);
      if (skip_count < skip_period) begin
        skip_count++;
      end else begin
        skip_count = 0;
        for (int i = 0; i < WINDOW_DEPTH - 1; i++) speed_history[i] = speed_history[i+1];
        speed_history[WINDOW_DEPTH-1] = speed_now;
        if (entries <= WINDOW_DEPTH) begin
          entries++;
        end else begin
          median_now = window_median();
          entries = WINDOW_DEPTH + 2;
        end
      end
    end
    r.actual_speed   = speed_now[18:0];
    r.filtered_speed = median_now[18:0];
    r.filtered_valid = (entries == WINDOW_DEPTH + 2);
    expected_results.push_back(r);
  endfunction

  // Driver: predict on each accepted transaction, then offer the next position
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) predict_speed_sample(s_tdata[22:0]);
      if (!s_tvalid || s_tready) begin
        if (pending_positions.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          s_tdata  <= {1'b0, pending_positions.pop_front()};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transaction against the oldest expectation
  always @(posedge clk) begin : result_monitor
    speed_result_t oldest;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none, actual tdata %h tuser %b",
                   $time, m_tdata, m_tuser);
        end else begin
          oldest = expected_results.pop_front();
          if (m_tdata[18:0] !== oldest.actual_speed) begin
            mismatch_count++;
            $display("%0t: actual_speed expected %0d actual %0d", $time,
                     oldest.actual_speed, $signed(m_tdata[18:0]));
          end
          if (m_tdata[37:19] !== oldest.filtered_speed) begin
            mismatch_count++;
            $display("%0t: filtered_speed expected %0d actual %0d", $time,
                     oldest.filtered_speed, $signed(m_tdata[37:19]));
          end
          if (m_tuser !== oldest.filtered_valid) begin
            mismatch_count++;
            $display("%0t: filtered_valid expected %b actual %b", $time,
                     oldest.filtered_valid, m_tuser);
          end
        end
      end
      m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Write one register and mirror it in the estimator
  task automatic write_reg(logic [esmf_pkg::CFG_ADDR_W-1:0] addr,
                           logic [esmf_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (addr)
      esmf_pkg::REG_ENCODER_RESOLUTION: resolution_23 = data[0];
      esmf_pkg::REG_SCALE_MODE:         magnetic_scale = data[0];
      esmf_pkg::REG_DECIMATION_PERIOD:  skip_period = data;
      default: ;
    endcase
  endtask

  // Hold until every queued position is sent and every result has arrived
  task automatic wait_drained();
    while (pending_positions.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Queue runs of a random walk, with occasional jumps and half-turn steps
  task automatic queue_walk(int count);
    int step;
    int half;
    int max_step;
    int run_left;
    half = resolution_23 ? int'(HALF_WIDE) : int'(HALF_NARROW);
    run_left = 0;
    max_step = 0;
    repeat (count) begin
      if (run_left == 0) begin
        run_left = $urandom_range(5, 30);
        case ($urandom_range(4))
          0: max_step = 0;
          1: max_step = 8;
          2: max_step = 500;
          3: max_step = half / 8;
          default: max_step = half;
        endcase
      end
      run_left--;
      case ($urandom_range(19))
        0: walk_position = $urandom_range(0, 23'h7FFFFF);
        1: walk_position = walk_position + ($urandom_range(1) ? half : -half);
        default: begin
          step = $urandom_range(0, 2 * max_step) - max_step;
          walk_position = walk_position + step;
        end
      endcase
      // Garbage in the unused upper bits at 17-bit resolution
      if (!resolution_23 && $urandom_range(1)) walk_position[22:17] = $urandom_range(0, 63);
      pending_positions.push_back(walk_position);
    end
  endtask

  task automatic run_phase(logic [15:0] res_data, logic [15:0] scale_data,
                           logic [15:0] period_data, int send_idle, int recv_stall,
                           int count, bit pause_midway);
    write_reg(esmf_pkg::REG_ENCODER_RESOLUTION, res_data);
    write_reg(esmf_pkg::REG_SCALE_MODE, scale_data);
    write_reg(esmf_pkg::REG_DECIMATION_PERIOD, period_data);
    sender_idle_pct = send_idle;
    receiver_stall_pct = recv_stall;
    if (pause_midway) begin
      queue_walk(count / 2);
      wait_drained();
      queue_walk(count - count / 2);
    end else begin
      queue_walk(count);
    end
    wait_drained();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
  endtask

  initial begin
    clear_estimator();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Start-up: extremes first, end on zero so the next differences are known
    pending_positions.push_back(23'h7FFFFF);
    pending_positions.push_back(23'h000000);
    repeat (47) pending_positions.push_back($urandom_range(0, 23'h7FFFFF));
    pending_positions.push_back(23'h000000);
    wait_drained();

    // 17-bit: exact half turn both ways, just past half, upper bits ignored, -1
    foreach (pending_positions[i]) ;
    pending_positions = '{23'h010000, 23'h000000, 23'h010001, 23'h000000,
                          23'h7E0005, 23'h01FFFF, 23'h000000, 23'h7FFFFF};
    wait_drained();

    // 23-bit: exact half turn both ways, just past half, -1 on the full turn
    write_reg(esmf_pkg::REG_ENCODER_RESOLUTION, 16'h0001);
    pending_positions = '{23'h000000, 23'h400000, 23'h000000, 23'h400001,
                          23'h000000, 23'h7FFFFF, 23'h000000};
    wait_drained();

    run_phase(16'h0000, 16'h0000, 16'h0000, 0, 0, 80, 1'b0);
    run_phase(16'h0000, 16'h0003, 16'h0001, 82, 0, 60, 1'b0);
    run_phase(16'h0001, 16'h0000, 16'h0000, 0, 82, 80, 1'b0);
    run_phase(16'h0001, 16'h0001, 16'h0002, 31, 31, 70, 1'b0);
    // Unmapped index must be ignored; resolution data is masked to one bit
    write_reg(REG_UNMAPPED, 16'hFFFF);
    run_phase(16'hFFFE, 16'h0001, 16'hFFFF, 0, 0, 20, 1'b0);
    run_phase(16'h0001, 16'h0000, 16'h0000, 82, 0, 80, 1'b1);
    run_phase(16'h0000, 16'h0000, 16'($urandom_range(0, 3)), 31, 31, 90, 1'b0);

    // Let any late result show up before judging
    repeat (300) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
